[sv/wakeup_timer_table_macros.svh]
// Assertion macros used by the wake-up timer table top level.
`ifndef WAKEUP_TIMER_TABLE_MACROS_SVH
`define WAKEUP_TIMER_TABLE_MACROS_SVH

// Check a property every clock edge outside reset.
`define WTT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next.
`define WTT_ASSERT_NEXT(label, clk, rst, cond, nxt, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) else $error(msg);

`endif

[sv/wtt_pkg.sv]
// Types and codes shared by the wake-up timer table modules.
package wtt_pkg;

   localparam logic [1:0] MODE_SET     = 2'd0;
   localparam logic [1:0] MODE_CLEAR   = 2'd1;
   localparam logic [1:0] MODE_REFRESH = 2'd2;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  owner_id;
      logic [15:0] ticks;
      logic [15:0] elapsed;
   } req_type;

   typedef struct packed {
      logic        next_valid;
      logic [7:0]  next_thread;
      logic [15:0] next_time;
      logic        table_full;
   } rsp_type;

   // Running state handed from one slot cell to the next.
   typedef struct packed {
      logic        active;
      logic        found;
      logic [15:0] best_time;
      logic [7:0]  best_thread;
      logic        placed;
      logic        full;
   } carry_type;

endpackage

[sv/wakeup_timer_table.sv]
// Top level of the wake-up timer table: a chain of slot cells and the request sequencer.
//
// Wake-up timer table. Pulse start while busy is low to hand in one item (set, clear or
// refresh); busy rises at once and stays high until the result item goes out. Each
// item walks the chain of SLOTS slot cells, one cell per cycle, with the running
// earliest deadline and the set placement handed from cell to cell. The result item
// shows on rsp_item for exactly one cycle with rsp_valid high, registered once the token
// has left the last slot cell; busy falls on that same edge, so the block takes no new item
// until the result goes out. The receiver cannot stall: capture rsp_item whenever rsp_valid is
// high. Clear and the unused mode walk the chain too and report the stored earliest
// deadline unchanged.
`include "wakeup_timer_table_macros.svh"

module wakeup_timer_table #(
   parameter int SLOTS = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  wtt_pkg::req_type  req_item,
   output logic              rsp_valid,
   output wtt_pkg::rsp_type  rsp_item
);

   wtt_pkg::req_type   cmd_ff, cmd_in;
   logic               busy_ff, busy_in;
   logic               launch_ff, launch_in;
   logic               rsp_valid_ff, rsp_valid_in;
   wtt_pkg::rsp_type   rsp_item_ff, rsp_item_in;
   logic               earliest_valid_ff, earliest_valid_in;
   logic [7:0]         earliest_thread_ff, earliest_thread_in;
   logic [15:0]        earliest_time_ff, earliest_time_in;
   wtt_pkg::carry_type chain [SLOTS+1];
   logic [SLOTS:0]     active_vec;
   logic               accept;
   logic               done;
   logic               refreshed;
   wtt_pkg::carry_type tail;

   assign accept = start && !busy_ff;

   // Seed the chain: only the token is set, no minimum found, nothing placed yet.
   always_comb begin
      chain[0]        = '0;
      chain[0].active = launch_ff;
   end

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      wtt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd_ff),
         .is_last   ((i == SLOTS - 1) ? 1'b1 : 1'b0),
         .carry_in  (chain[i]),
         .carry_out (chain[i+1])
      );
   end

   for (genvar i = 0; i <= SLOTS; i++) begin : g_active
      assign active_vec[i] = chain[i].active;
   end

   assign tail      = chain[SLOTS];
   assign done      = tail.active;
   assign refreshed = (cmd_ff.mode == wtt_pkg::MODE_SET) ||
                      (cmd_ff.mode == wtt_pkg::MODE_REFRESH);

   always_comb begin
      cmd_in             = cmd_ff;
      busy_in            = busy_ff;
      launch_in          = 1'b0;
      rsp_valid_in       = 1'b0;
      rsp_item_in        = rsp_item_ff;
      earliest_valid_in  = earliest_valid_ff;
      earliest_thread_in = earliest_thread_ff;
      earliest_time_in   = earliest_time_ff;
      if (accept) begin
         // hold the item for the whole walk and launch the token
         cmd_in    = req_item;
         busy_in   = 1'b1;
         launch_in = 1'b1;
      end
      if (done) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b1;
         if (refreshed) begin
            // drop to zeros when no slot is left pending
            earliest_valid_in  = tail.found;
            earliest_thread_in = tail.found ? tail.best_thread : 8'd0;
            earliest_time_in   = tail.found ? tail.best_time : 16'd0;
         end
         rsp_item_in.next_valid  = earliest_valid_in;
         rsp_item_in.next_thread = earliest_thread_in;
         rsp_item_in.next_time   = earliest_time_in;
         rsp_item_in.table_full  = (cmd_ff.mode == wtt_pkg::MODE_SET) && tail.full;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff            <= 1'b0;
         launch_ff          <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         earliest_valid_ff  <= 1'b0;
         earliest_thread_ff <= '0;
         earliest_time_ff   <= '0;
      end else begin
         busy_ff            <= busy_in;
         launch_ff          <= launch_in;
         rsp_valid_ff       <= rsp_valid_in;
         earliest_valid_ff  <= earliest_valid_in;
         earliest_thread_ff <= earliest_thread_in;
         earliest_time_ff   <= earliest_time_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // At most one token walks the chain.
   `WTT_ASSERT(a_one_token, clock, reset, $onehot0(active_vec), "more than one token in chain")
   // An accepted item makes the block busy.
   `WTT_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy_ff, "accept did not raise busy")
   // A result goes out only as the walk finishes, with busy already dropped.
   `WTT_ASSERT(a_rsp_idle, clock, reset, !rsp_valid_ff || !busy_ff, "result while busy")
   // A token in the chain means an item is in flight.
   `WTT_ASSERT(a_token_busy, clock, reset, !(|active_vec) || busy_ff, "token while idle")

endmodule

[sv/wtt_cell.sv]
// One timer slot cell: holds a slot and updates the running minimum passing through.
module wtt_cell (
   input  logic                clock,
   input  logic                reset,
   input  wtt_pkg::req_type    cmd,
   input  logic                is_last,
   input  wtt_pkg::carry_type  carry_in,
   output wtt_pkg::carry_type  carry_out
);

   logic               used_ff,   used_in;
   logic [15:0]        remain_ff, remain_in;
   logic [7:0]         thread_ff, thread_in;
   wtt_pkg::carry_type carry_ff,  carry_in_next;
   logic               write_slot;
   logic [16:0]        diff;
   logic               do_refresh;

   always_comb begin
      used_in       = used_ff;
      remain_in     = remain_ff;
      thread_in     = thread_ff;
      carry_in_next = carry_in;
      write_slot    = 1'b0;
      do_refresh    = (cmd.mode == wtt_pkg::MODE_SET) || (cmd.mode == wtt_pkg::MODE_REFRESH);
      diff          = {1'b0, remain_ff} - {1'b0, cmd.elapsed};
      if (carry_in.active) begin
         if (cmd.mode == wtt_pkg::MODE_SET && !carry_in.placed) begin
            // take the first free slot; the last slot takes it anyway
            write_slot = !used_ff || is_last;
            if (write_slot) begin
               used_in              = 1'b1;
               remain_in            = cmd.ticks;
               thread_in            = cmd.owner_id;
               carry_in_next.placed = 1'b1;
               carry_in_next.full   = carry_in.full | used_ff;
            end
         end
         if (cmd.mode == wtt_pkg::MODE_CLEAR && thread_ff == cmd.owner_id) begin
            used_in = 1'b0;
         end
         if (do_refresh && used_in) begin
            diff = {1'b0, remain_in} - {1'b0, cmd.elapsed};
            if (diff[16]) begin
               used_in   = 1'b0;
               remain_in = diff[15:0];
            end else begin
               remain_in = diff[15:0];
               if (!carry_in.found || diff[15:0] < carry_in.best_time ||
                   (diff[15:0] == carry_in.best_time && thread_in < carry_in.best_thread)) begin
                  carry_in_next.found       = 1'b1;
                  carry_in_next.best_time   = diff[15:0];
                  carry_in_next.best_thread = thread_in;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff   <= 1'b0;
         remain_ff <= '0;
         thread_ff <= '0;
         carry_ff  <= '0;
      end else begin
         used_ff   <= used_in;
         remain_ff <= remain_in;
         thread_ff <= thread_in;
         carry_ff  <= carry_in_next;
      end
   end

   assign carry_out = carry_ff;

endmodule
